/* rtl/yrl_pkg.sv */
`default_nettype none

package yrl_pkg;

    // Field and register widths
    localparam int SAMPLE_W   = 8;
    localparam int NUM_LUMA   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int MODE_W     = 3;
    localparam int FMT_W      = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LUMA_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHROMA_HIGH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_MODE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 3'd5;

    // Marking modes; codes 5..7 fall back to clamping
    localparam logic [MODE_W-1:0] MODE_CLAMP       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LUMA        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LUMA_GREY   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CHROMA      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CHROMA_GREY = 3'd4;

    // Sample formats; code 3 behaves as 4:2:0
    localparam logic [FMT_W-1:0] FMT_444 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_422 = 2'd1;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] RST_LUMA_LOW    = 8'd16;
    localparam logic [SAMPLE_W-1:0] RST_LUMA_HIGH   = 8'd235;
    localparam logic [SAMPLE_W-1:0] RST_CHROMA_LOW  = 8'd16;
    localparam logic [SAMPLE_W-1:0] RST_CHROMA_HIGH = 8'd240;

    // Marking colors
    localparam logic [SAMPLE_W-1:0] Y_LOW_MARK  = 8'd81;
    localparam logic [SAMPLE_W-1:0] Y_HIGH_MARK = 8'd145;
    localparam logic [SAMPLE_W-1:0] Y_YELLOW    = 8'd210;
    localparam logic [SAMPLE_W-1:0] U_RED       = 8'd91;
    localparam logic [SAMPLE_W-1:0] V_RED       = 8'd240;
    localparam logic [SAMPLE_W-1:0] U_GREEN     = 8'd54;
    localparam logic [SAMPLE_W-1:0] V_GREEN     = 8'd34;
    localparam logic [SAMPLE_W-1:0] U_YELLOW    = 8'd16;
    localparam logic [SAMPLE_W-1:0] V_YELLOW    = 8'd146;
    localparam logic [SAMPLE_W-1:0] U_BOTH      = 8'd90;
    localparam logic [SAMPLE_W-1:0] V_BOTH      = 8'd134;
    localparam logic [SAMPLE_W-1:0] C_GREY      = 8'd128;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // Range class of one sample; below is tested first, so both are never set
    typedef struct packed {
        logic below;
        logic above;
    } cls_t;

    typedef struct packed {
        sample_t y;
        sample_t u;
        sample_t v;
    } color_t;

    // Stage 1: raw site plus range classes
    typedef struct packed {
        logic [NUM_LUMA-1:0][SAMPLE_W-1:0] y;
        cls_t [NUM_LUMA-1:0]               ycls;
        sample_t                           u;
        sample_t                           v;
        cls_t                              ucls;
        cls_t                              vcls;
    } s1_t;

    // Stage 2: candidate values for every mode
    typedef struct packed {
        logic [NUM_LUMA-1:0][SAMPLE_W-1:0] y_raw;
        logic [NUM_LUMA-1:0][SAMPLE_W-1:0] y_mark;
        logic [NUM_LUMA-1:0][SAMPLE_W-1:0] y_clamp;
        logic [NUM_LUMA-1:0]               used;
        logic                              any_low;
        logic                              any_high;
        sample_t                           u;
        sample_t                           v;
        sample_t                           u_clamp;
        sample_t                           v_clamp;
        cls_t                              ucls;
        cls_t                              vcls;
    } s2_t;

    // Lumas in use for a format
    function automatic logic [NUM_LUMA-1:0] used_mask(input logic [FMT_W-1:0] fmt);
        logic [NUM_LUMA-1:0] m;
        case (fmt)
            FMT_444: m = 4'b0001;
            FMT_422: m = 4'b0011;
            default: m = 4'b1111;
        endcase
        return m;
    endfunction

    // Chroma-grey color table; the in-range entry is never used
    function automatic color_t grey_color(input cls_t uc, input cls_t vc);
        color_t c;
        case ({uc, vc})
            4'b00_10: c = '{y: 8'd170, u: 8'd165, v: 8'd16};
            4'b00_01: c = '{y: 8'd81,  u: 8'd91,  v: 8'd240};
            4'b10_00: c = '{y: 8'd210, u: 8'd16,  v: 8'd146};
            4'b10_10: c = '{y: 8'd153, u: 8'd49,  v: 8'd49};
            4'b10_01: c = '{y: 8'd146, u: 8'd53,  v: 8'd193};
            4'b01_00: c = '{y: 8'd41,  u: 8'd240, v: 8'd110};
            4'b01_10: c = '{y: 8'd105, u: 8'd203, v: 8'd63};
            4'b01_01: c = '{y: 8'd106, u: 8'd202, v: 8'd222};
            default:  c = '{y: 8'd0,   u: 8'd0,   v: 8'd0};
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/yrl_if.sv */
`default_nettype none

// Input site channel
interface yrl_in_if;
    logic                     valid;
    logic                     ready;
    logic [yrl_pkg::SAMPLE_W-1:0] luma_a;
    logic [yrl_pkg::SAMPLE_W-1:0] luma_b;
    logic [yrl_pkg::SAMPLE_W-1:0] luma_c;
    logic [yrl_pkg::SAMPLE_W-1:0] luma_d;
    logic [yrl_pkg::SAMPLE_W-1:0] chroma_u;
    logic [yrl_pkg::SAMPLE_W-1:0] chroma_v;

    modport source (
        output valid, luma_a, luma_b, luma_c, luma_d, chroma_u, chroma_v,
        input  ready
    );
    modport sink (
        input  valid, luma_a, luma_b, luma_c, luma_d, chroma_u, chroma_v,
        output ready
    );
endinterface

// Output site channel
interface yrl_out_if;
    logic                     valid;
    logic                     ready;
    logic [yrl_pkg::SAMPLE_W-1:0] out_luma_a;
    logic [yrl_pkg::SAMPLE_W-1:0] out_luma_b;
    logic [yrl_pkg::SAMPLE_W-1:0] out_luma_c;
    logic [yrl_pkg::SAMPLE_W-1:0] out_luma_d;
    logic [yrl_pkg::SAMPLE_W-1:0] out_chroma_u;
    logic [yrl_pkg::SAMPLE_W-1:0] out_chroma_v;

    modport source (
        output valid, out_luma_a, out_luma_b, out_luma_c, out_luma_d,
               out_chroma_u, out_chroma_v,
        input  ready
    );
    modport sink (
        input  valid, out_luma_a, out_luma_b, out_luma_c, out_luma_d,
               out_chroma_u, out_chroma_v,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/yrl_classify.sv */
`default_nettype none

// Range class of one sample against [low, high]; below wins when low > high
module yrl_classify (
    input  wire yrl_pkg::sample_t value,
    input  wire yrl_pkg::sample_t low,
    input  wire yrl_pkg::sample_t high,
    output yrl_pkg::cls_t         cls
);

    always_comb
    begin
        cls.below = (value < low);
        cls.above = !(value < low) && (value > high);
    end

endmodule

`default_nettype wire

/* rtl/yuv_range_limiter_with_marking_core.sv */
`default_nettype none

// Channel     Dir  Payload                                  Transfer
// site_in     in   luma_a..luma_d, chroma_u, chroma_v       valid & ready
// site_out    out  out_luma_a..out_luma_d, out_chroma_u/v   valid & ready
// cfg         in   cfg_index, cfg_wdata                     cfg_we
//
// Three register stages: classify, candidate values, final select.
// One site per cycle is sustained while the output is not stalled.
// Each stage has its own valid bit and loads when it is empty or its
// successor moves, so bubbles fill while the output is stalled.
// rst_n clears the valid bits and loads the register reset values.
module yuv_range_limiter_with_marking_core (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_we,
    input  wire [yrl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [yrl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    yrl_in_if.sink                             site_in,
    yrl_out_if.source                          site_out
);

    // Configuration registers
    yrl_pkg::sample_t                luma_low_reg;
    yrl_pkg::sample_t                luma_high_reg;
    yrl_pkg::sample_t                chroma_low_reg;
    yrl_pkg::sample_t                chroma_high_reg;
    logic [yrl_pkg::MODE_W-1:0]      show_mode_reg;
    logic [yrl_pkg::FMT_W-1:0]       sample_format_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_low_reg      <= yrl_pkg::RST_LUMA_LOW;
            luma_high_reg     <= yrl_pkg::RST_LUMA_HIGH;
            chroma_low_reg    <= yrl_pkg::RST_CHROMA_LOW;
            chroma_high_reg   <= yrl_pkg::RST_CHROMA_HIGH;
            show_mode_reg     <= yrl_pkg::MODE_CLAMP;
            sample_format_reg <= yrl_pkg::FMT_444;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                yrl_pkg::REG_LUMA_LOW:      luma_low_reg      <= cfg_wdata;
                yrl_pkg::REG_LUMA_HIGH:     luma_high_reg     <= cfg_wdata;
                yrl_pkg::REG_CHROMA_LOW:    chroma_low_reg    <= cfg_wdata;
                yrl_pkg::REG_CHROMA_HIGH:   chroma_high_reg   <= cfg_wdata;
                yrl_pkg::REG_SHOW_MODE:
                    show_mode_reg <= cfg_wdata[yrl_pkg::MODE_W-1:0];
                yrl_pkg::REG_SAMPLE_FORMAT:
                    sample_format_reg <= cfg_wdata[yrl_pkg::FMT_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake chain
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic s1_ready, s2_ready, out_ready;

    assign out_ready     = !out_valid_reg || site_out.ready;
    assign s2_ready      = !s2_valid_reg || out_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign site_in.ready = s1_ready;

    assign s1_valid_next  = s1_ready  ? site_in.valid : s1_valid_reg;
    assign s2_valid_next  = s2_ready  ? s1_valid_reg  : s2_valid_reg;
    assign out_valid_next = out_ready ? s2_valid_reg  : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Stage 1: classify every sample
    yrl_pkg::s1_t s1_reg, s1_next;
    logic [yrl_pkg::NUM_LUMA-1:0][yrl_pkg::SAMPLE_W-1:0] in_y;

    assign in_y = {site_in.luma_d, site_in.luma_c, site_in.luma_b, site_in.luma_a};

    genvar gi;
    generate
        for (gi = 0; gi < yrl_pkg::NUM_LUMA; gi++)
        begin : g_ycls
            yrl_classify u_ycls (
                .value (in_y[gi]),
                .low   (luma_low_reg),
                .high  (luma_high_reg),
                .cls   (s1_next.ycls[gi])
            );
        end
    endgenerate

    yrl_classify u_ucls (
        .value (site_in.chroma_u),
        .low   (chroma_low_reg),
        .high  (chroma_high_reg),
        .cls   (s1_next.ucls)
    );

    yrl_classify u_vcls (
        .value (site_in.chroma_v),
        .low   (chroma_low_reg),
        .high  (chroma_high_reg),
        .cls   (s1_next.vcls)
    );

    assign s1_next.y = in_y;
    assign s1_next.u = site_in.chroma_u;
    assign s1_next.v = site_in.chroma_v;

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_reg <= s1_next;
        end
    end

    // Stage 2: marks, clamps and summary flags
    yrl_pkg::s2_t s2_reg, s2_next;

    always_comb
    begin
        logic [yrl_pkg::NUM_LUMA-1:0] lo_v;
        logic [yrl_pkg::NUM_LUMA-1:0] hi_v;
        s2_next.used = yrl_pkg::used_mask(sample_format_reg);
        for (int i = 0; i < yrl_pkg::NUM_LUMA; i++)
        begin
            lo_v[i] = s1_reg.ycls[i].below;
            hi_v[i] = s1_reg.ycls[i].above;
            s2_next.y_raw[i] = s1_reg.y[i];
            if (s1_reg.ycls[i].below)
            begin
                s2_next.y_mark[i]  = yrl_pkg::Y_LOW_MARK;
                s2_next.y_clamp[i] = luma_low_reg;
            end
            else if (s1_reg.ycls[i].above)
            begin
                s2_next.y_mark[i]  = yrl_pkg::Y_HIGH_MARK;
                s2_next.y_clamp[i] = luma_high_reg;
            end
            else
            begin
                s2_next.y_mark[i]  = s1_reg.y[i];
                s2_next.y_clamp[i] = s1_reg.y[i];
            end
        end
        s2_next.any_low  = |(lo_v & s2_next.used);
        s2_next.any_high = |(hi_v & s2_next.used);
        s2_next.u    = s1_reg.u;
        s2_next.v    = s1_reg.v;
        s2_next.ucls = s1_reg.ucls;
        s2_next.vcls = s1_reg.vcls;
        s2_next.u_clamp = s1_reg.ucls.below ? chroma_low_reg :
                          s1_reg.ucls.above ? chroma_high_reg : s1_reg.u;
        s2_next.v_clamp = s1_reg.vcls.below ? chroma_low_reg :
                          s1_reg.vcls.above ? chroma_high_reg : s1_reg.v;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
        begin
            s2_reg <= s2_next;
        end
    end

    // Stage 3: select by mode into the output register
    logic [yrl_pkg::NUM_LUMA-1:0][yrl_pkg::SAMPLE_W-1:0] y_out_reg, y_out_next;
    yrl_pkg::sample_t u_out_reg, u_out_next;
    yrl_pkg::sample_t v_out_reg, v_out_next;

    always_comb
    begin
        yrl_pkg::color_t gc;
        logic            chroma_bad;
        logic            both;
        gc         = yrl_pkg::grey_color(s2_reg.ucls, s2_reg.vcls);
        chroma_bad = s2_reg.ucls.below || s2_reg.ucls.above ||
                     s2_reg.vcls.below || s2_reg.vcls.above;
        both       = s2_reg.any_low && s2_reg.any_high;
        y_out_next = s2_reg.y_raw;
        u_out_next = s2_reg.u;
        v_out_next = s2_reg.v;
        case (show_mode_reg)
            yrl_pkg::MODE_LUMA, yrl_pkg::MODE_LUMA_GREY:
            begin
                for (int i = 0; i < yrl_pkg::NUM_LUMA; i++)
                begin
                    if (s2_reg.used[i])
                    begin
                        y_out_next[i] = (both && show_mode_reg == yrl_pkg::MODE_LUMA) ?
                                        yrl_pkg::Y_YELLOW : s2_reg.y_mark[i];
                    end
                end
                if (both)
                begin
                    if (show_mode_reg == yrl_pkg::MODE_LUMA)
                    begin
                        u_out_next = yrl_pkg::U_YELLOW;
                        v_out_next = yrl_pkg::V_YELLOW;
                    end
                    else
                    begin
                        u_out_next = yrl_pkg::U_BOTH;
                        v_out_next = yrl_pkg::V_BOTH;
                    end
                end
                else if (s2_reg.any_low)
                begin
                    u_out_next = yrl_pkg::U_RED;
                    v_out_next = yrl_pkg::V_RED;
                end
                else if (s2_reg.any_high)
                begin
                    u_out_next = yrl_pkg::U_GREEN;
                    v_out_next = yrl_pkg::V_GREEN;
                end
                else if (show_mode_reg == yrl_pkg::MODE_LUMA_GREY)
                begin
                    u_out_next = yrl_pkg::C_GREY;
                    v_out_next = yrl_pkg::C_GREY;
                end
            end
            yrl_pkg::MODE_CHROMA:
            begin
                if (chroma_bad)
                begin
                    for (int i = 0; i < yrl_pkg::NUM_LUMA; i++)
                    begin
                        if (s2_reg.used[i])
                        begin
                            y_out_next[i] = yrl_pkg::Y_YELLOW;
                        end
                    end
                    u_out_next = yrl_pkg::U_YELLOW;
                    v_out_next = yrl_pkg::V_YELLOW;
                end
            end
            yrl_pkg::MODE_CHROMA_GREY:
            begin
                if (chroma_bad)
                begin
                    for (int i = 0; i < yrl_pkg::NUM_LUMA; i++)
                    begin
                        if (s2_reg.used[i])
                        begin
                            y_out_next[i] = gc.y;
                        end
                    end
                    u_out_next = gc.u;
                    v_out_next = gc.v;
                end
                else
                begin
                    u_out_next = yrl_pkg::C_GREY;
                    v_out_next = yrl_pkg::C_GREY;
                end
            end
            default:
            begin
                for (int i = 0; i < yrl_pkg::NUM_LUMA; i++)
                begin
                    if (s2_reg.used[i])
                    begin
                        y_out_next[i] = s2_reg.y_clamp[i];
                    end
                end
                u_out_next = s2_reg.u_clamp;
                v_out_next = s2_reg.v_clamp;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            y_out_reg <= y_out_next;
            u_out_reg <= u_out_next;
            v_out_reg <= v_out_next;
        end
    end

    assign site_out.valid        = out_valid_reg;
    assign site_out.out_luma_a   = y_out_reg[0];
    assign site_out.out_luma_b   = y_out_reg[1];
    assign site_out.out_luma_c   = y_out_reg[2];
    assign site_out.out_luma_d   = y_out_reg[3];
    assign site_out.out_chroma_u = u_out_reg;
    assign site_out.out_chroma_v = v_out_reg;

    // An accepted site always lands in stage 1
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (site_in.valid && site_in.ready) |=> s1_valid_reg)
        else $error("accepted site not captured in stage 1");

    // A stalled stage 1 keeps its site
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("stage 1 lost or changed a stalled site");

    // A stalled stage 2 keeps its site
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !out_ready) |=> (s2_valid_reg && $stable(s2_reg)))
        else $error("stage 2 lost or changed a stalled site");

    // A full stage 2 moves on when the output takes it
    a_s2_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && out_ready) |=> out_valid_reg)
        else $error("stage 2 site not moved to output");

endmodule

`default_nettype wire
